@@ src/tcrr_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tcrr_pkg
// Shared types and constants of the two-class interleaved round-robin
// scheduler: payload structs, membership codes and the link store interface.
// ---------------------------------------------------------------------------
package tcrr_pkg;

    // Node space. The rings hold node numbers below MAX_NODES.
    localparam int MAX_NODES = 256;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LEN_W     = $clog2(MAX_NODES + 1);

    // Fixed field widths of the channels.
    localparam int KIND_W  = 2;
    localparam int ID_W    = 8;
    localparam int CNT_W   = 9;
    localparam int RATIO_W = 8;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_REGISTER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TO_ACTIVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TO_STANDBY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REQUEST    = 2'd3;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd1;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LEN_W-1:0]  len_t;

    // Which ring holds a node.
    typedef enum logic [1:0] {
        MEMB_NONE    = 2'd0,
        MEMB_ACTIVE  = 2'd1,
        MEMB_STANDBY = 2'd2
    } memb_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   node_id;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]  next_node;
        logic             next_valid;
        logic             from_standby;
        logic [CNT_W-1:0] active_count;
        logic [CNT_W-1:0] standby_count;
    } result_t;

    // Word of the forward link memory: the ring a node sits in and its successor.
    typedef struct packed {
        memb_t memb;
        node_t next;
    } next_word_t;

    typedef struct packed {
        logic  en;
        node_t next_addr;
        node_t prev_addr_a;
        node_t prev_addr_b;
    } link_rd_t;

    typedef struct packed {
        logic       next_we;
        node_t      next_addr;
        next_word_t next_data;
        logic       prev_we;
        node_t      prev_addr;
        node_t      prev_data;
    } link_wr_t;

    typedef struct packed {
        next_word_t next_word;
        node_t      prev_a;
        node_t      prev_b;
    } link_rsp_t;

endpackage : tcrr_pkg
`default_nettype wire

@@ src/tcrr_link_store.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tcrr_link_store
// Doubly linked ring storage indexed by node number. The forward memory also
// carries the membership code, which reads as "in no ring" until the entry
// has been written once since reset.
// ---------------------------------------------------------------------------
module tcrr_link_store (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tcrr_pkg::link_rd_t rd,
    input  wire tcrr_pkg::link_wr_t wr,
    output tcrr_pkg::link_rsp_t     rsp
);
    import tcrr_pkg::*;

    next_word_t             next_mem [MAX_NODES];
    node_t                  prev_mem [MAX_NODES];
    logic [MAX_NODES-1:0]   written_reg;

    next_word_t next_rd_reg;
    node_t      prev_a_rd_reg;
    node_t      prev_b_rd_reg;
    logic       written_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.next_we)
        begin
            next_mem[wr.next_addr] <= wr.next_data;
        end
        if (wr.prev_we)
        begin
            prev_mem[wr.prev_addr] <= wr.prev_data;
        end
        if (rd.en)
        begin
            next_rd_reg   <= next_mem[rd.next_addr];
            prev_a_rd_reg <= prev_mem[rd.prev_addr_a];
            prev_b_rd_reg <= prev_mem[rd.prev_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            written_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.next_we)
            begin
                written_reg[wr.next_addr] <= 1'b1;
            end
            if (rd.en)
            begin
                written_rd_reg <= written_reg[rd.next_addr];
            end
        end
    end

    always_comb
    begin
        rsp.next_word.next = next_rd_reg.next;
        rsp.next_word.memb = written_rd_reg ? next_rd_reg.memb : MEMB_NONE;
        rsp.prev_a         = prev_a_rd_reg;
        rsp.prev_b         = prev_b_rd_reg;
    end

endmodule : tcrr_link_store
`default_nettype wire

@@ src/two_class_interleaved_round_robin.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// two_class_interleaved_round_robin
// Two-class round-robin node scheduler with an active and a standby ring.
// ---------------------------------------------------------------------------
// The block keeps an active ring and a standby ring of node numbers as
// circular doubly linked lists in a link store indexed by node number, so a
// node is taken out of the middle of a ring in one step, without moving the
// others. Every transaction on the item channel returns exactly one
// transaction on the result channel. A request serves the active ring until
// the configured ratio of services has been given, then one standby node,
// whenever both rings hold nodes; with only one ring occupied that ring
// rotates. The block works on one item at a time: a request or an item that
// changes nothing passes the lookup and completion states; any other
// register or move also passes the first append state in between, and
// the second one as well when the target ring is occupied. These steps
// follow the read-modify-write path through the link store, whose two
// memories each take one write per cycle, so the tail insertion is split
// over the append states. The result is held in an output register, so a
// stalled result channel holds back only the completion of the following
// item. The membership marks are cleared at reset through per-entry valid
// bits, so no clearing pass is needed and the block takes items straight
// out of reset. The ratio register is written through the cfg channel,
// which is always ready.
// ---------------------------------------------------------------------------
module two_class_interleaved_round_robin (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire tcrr_pkg::item_t                item,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output tcrr_pkg::result_t                   result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tcrr_pkg::RATIO_W-1:0]   cfg_data
);
    import tcrr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_APP1,
        ST_APP2,
        ST_DONE
    } state_t;

    // Which ring a request serves.
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_ACTIVE,
        SEL_STANDBY
    } sel_t;

    state_t               state_reg;
    logic [KIND_W-1:0]    kind_reg;
    node_t                node_reg;
    logic                 id_ok_reg;
    sel_t                 sel_reg;
    memb_t                target_reg;
    node_t                tail_reg;

    node_t                a_head_reg;
    len_t                 a_len_reg;
    node_t                s_head_reg;
    len_t                 s_len_reg;
    logic [RATIO_W-1:0]   served_reg;
    logic [RATIO_W-1:0]   ratio_reg;

    node_t                res_node_reg;
    logic                 res_valid_reg;
    logic                 res_sb_reg;
    logic                 result_valid_reg;
    result_t              result_reg;

    link_rd_t             link_rd;
    link_wr_t             link_wr;
    link_rsp_t            link_rsp;

    logic                 item_accept;
    sel_t                 sel_now;
    logic                 is_edit;
    memb_t                cur_memb;
    memb_t                target_now;
    logic                 do_app;
    logic                 do_rem;
    len_t                 rem_len;
    node_t                t_head;
    len_t                 t_len;
    logic                 out_free;

    tcrr_link_store u_links (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (link_rd),
        .wr    (link_wr),
        .rsp   (link_rsp)
    );

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_accept  = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    // Service decision, taken from the ring sizes and the served count at acceptance.
    always_comb
    begin
        if (a_len_reg == '0 && s_len_reg == '0)
        begin
            sel_now = SEL_NONE;
        end
        else if (a_len_reg == '0)
        begin
            sel_now = SEL_STANDBY;
        end
        else if (s_len_reg == '0 || served_reg < ratio_reg)
        begin
            sel_now = SEL_ACTIVE;
        end
        else
        begin
            sel_now = SEL_STANDBY;
        end
    end

    // Reads issued at acceptance: the forward word of the served head or of
    // the node, the back link of the node and the back link of the target
    // ring's head, which is that ring's tail.
    always_comb
    begin
        link_rd.en          = item_accept;
        link_rd.prev_addr_a = node_t'(item.node_id);
        if (item.kind == KIND_REQUEST)
        begin
            link_rd.next_addr = (sel_now == SEL_ACTIVE) ? a_head_reg : s_head_reg;
        end
        else
        begin
            link_rd.next_addr = node_t'(item.node_id);
        end
        link_rd.prev_addr_b = (item.kind == KIND_TO_ACTIVE) ? a_head_reg : s_head_reg;
    end

    // Decisions of the lookup cycle for register and move items.
    always_comb
    begin
        is_edit    = (kind_reg != KIND_REQUEST) && id_ok_reg;
        cur_memb   = link_rsp.next_word.memb;
        target_now = (kind_reg == KIND_TO_ACTIVE) ? MEMB_ACTIVE : MEMB_STANDBY;
        if (kind_reg == KIND_REGISTER)
        begin
            do_app = (cur_memb == MEMB_NONE);
        end
        else
        begin
            do_app = (cur_memb != target_now);
        end
        do_rem  = do_app && (cur_memb != MEMB_NONE);
        rem_len = (cur_memb == MEMB_ACTIVE) ? a_len_reg : s_len_reg;
        t_head  = (target_reg == MEMB_ACTIVE) ? a_head_reg : s_head_reg;
        t_len   = (target_reg == MEMB_ACTIVE) ? a_len_reg : s_len_reg;
    end

    // Link writes. The unlink touches only the old ring and the insertion
    // touches only the new node and the target ring, so nothing read at
    // acceptance goes stale before it is used.
    always_comb
    begin
        link_wr = '0;
        case (state_reg)
            ST_LOOK:
            begin
                if (is_edit && do_rem && rem_len > LEN_W'(1))
                begin
                    link_wr.next_we        = 1'b1;
                    link_wr.next_addr      = link_rsp.prev_a;
                    link_wr.next_data.memb = cur_memb;
                    link_wr.next_data.next = link_rsp.next_word.next;
                    link_wr.prev_we        = 1'b1;
                    link_wr.prev_addr      = link_rsp.next_word.next;
                    link_wr.prev_data      = link_rsp.prev_a;
                end
            end
            ST_APP1:
            begin
                link_wr.next_we        = 1'b1;
                link_wr.next_addr      = node_reg;
                link_wr.next_data.memb = target_reg;
                link_wr.next_data.next = (t_len == '0) ? node_reg : t_head;
                link_wr.prev_we        = 1'b1;
                link_wr.prev_addr      = node_reg;
                link_wr.prev_data      = (t_len == '0) ? node_reg : tail_reg;
            end
            ST_APP2:
            begin
                link_wr.next_we        = 1'b1;
                link_wr.next_addr      = tail_reg;
                link_wr.next_data.memb = target_reg;
                link_wr.next_data.next = node_reg;
                link_wr.prev_we        = 1'b1;
                link_wr.prev_addr      = t_head;
                link_wr.prev_data      = node_reg;
            end
            default:
            begin
                link_wr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            kind_reg         <= KIND_REGISTER;
            node_reg         <= '0;
            id_ok_reg        <= 1'b0;
            sel_reg          <= SEL_NONE;
            target_reg       <= MEMB_NONE;
            tail_reg         <= '0;
            a_head_reg       <= '0;
            a_len_reg        <= '0;
            s_head_reg       <= '0;
            s_len_reg        <= '0;
            served_reg       <= '0;
            ratio_reg        <= RATIO_RESET;
            res_node_reg     <= '0;
            res_valid_reg    <= 1'b0;
            res_sb_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ratio_reg <= cfg_data;
            end

            // In the completion state the output register is reloaded instead.
            if (result_valid_reg && result_ready && state_reg != ST_DONE)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_accept)
                    begin
                        kind_reg      <= item.kind;
                        node_reg      <= node_t'(item.node_id);
                        id_ok_reg     <= (int'(item.node_id) < MAX_NODES);
                        sel_reg       <= sel_now;
                        res_node_reg  <= '0;
                        res_valid_reg <= 1'b0;
                        res_sb_reg    <= 1'b0;
                        state_reg     <= ST_LOOK;
                    end
                end

                ST_LOOK:
                begin
                    if (kind_reg == KIND_REQUEST)
                    begin
                        state_reg <= ST_DONE;
                        case (sel_reg)
                            SEL_ACTIVE:
                            begin
                                res_node_reg  <= a_head_reg;
                                res_valid_reg <= 1'b1;
                                a_head_reg    <= link_rsp.next_word.next;
                                if (served_reg != '1)
                                begin
                                    served_reg <= served_reg + RATIO_W'(1);
                                end
                            end
                            SEL_STANDBY:
                            begin
                                res_node_reg  <= s_head_reg;
                                res_valid_reg <= 1'b1;
                                res_sb_reg    <= 1'b1;
                                s_head_reg    <= link_rsp.next_word.next;
                                // The count restarts only on an interleaved turn.
                                if (a_len_reg != '0)
                                begin
                                    served_reg <= '0;
                                end
                            end
                            default:
                            begin
                                res_valid_reg <= 1'b0;
                            end
                        endcase
                    end
                    else if (is_edit && do_app)
                    begin
                        if (do_rem)
                        begin
                            if (cur_memb == MEMB_ACTIVE)
                            begin
                                if (a_head_reg == node_reg)
                                begin
                                    a_head_reg <= link_rsp.next_word.next;
                                end
                                a_len_reg <= a_len_reg - LEN_W'(1);
                            end
                            else
                            begin
                                if (s_head_reg == node_reg)
                                begin
                                    s_head_reg <= link_rsp.next_word.next;
                                end
                                s_len_reg <= s_len_reg - LEN_W'(1);
                            end
                        end
                        target_reg <= target_now;
                        tail_reg   <= link_rsp.prev_b;
                        state_reg  <= ST_APP1;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_APP1:
                begin
                    if (t_len == '0)
                    begin
                        if (target_reg == MEMB_ACTIVE)
                        begin
                            a_head_reg <= node_reg;
                            a_len_reg  <= LEN_W'(1);
                        end
                        else
                        begin
                            s_head_reg <= node_reg;
                            s_len_reg  <= LEN_W'(1);
                        end
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_APP2;
                    end
                end

                ST_APP2:
                begin
                    if (target_reg == MEMB_ACTIVE)
                    begin
                        a_len_reg <= a_len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        s_len_reg <= s_len_reg + LEN_W'(1);
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        result_reg.next_node     <= ID_W'(res_node_reg);
                        result_reg.next_valid    <= res_valid_reg;
                        result_reg.from_standby  <= res_sb_reg;
                        result_reg.active_count  <= CNT_W'(a_len_reg);
                        result_reg.standby_count <= CNT_W'(s_len_reg);
                        result_valid_reg         <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Every node sits in at most one ring, so the rings never hold more
    // nodes together than there are node numbers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(a_len_reg) + (CNT_W + 1)'(s_len_reg) <= (CNT_W + 1)'(MAX_NODES))
        else $error("ring sizes exceed the node space");

    // A request that found a node was served from a ring that is not empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_valid_reg) |-> (a_len_reg != '0 || s_len_reg != '0))
        else $error("valid service reported with both rings empty");

    // A standby service is always a valid service.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.from_standby |-> result_reg.next_valid)
        else $error("standby mark on an invalid result");

    // The served count moves only in the lookup cycle of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_LOOK && kind_reg == KIND_REQUEST) |=> $stable(served_reg))
        else $error("served count changed outside a request");

endmodule : two_class_interleaved_round_robin
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-class interleaved round-robin scheduler.
// ---------------------------------------------------------------------------
// A clocked driver feeds item transactions from a backlog queue. For every
// accepted item it runs a behavioral model of both rings and pushes the
// expected result. A clocked monitor compares each result transaction with
// the oldest expectation, field by field. Both sides idle in random bursts.
// The run walks through several interleave ratios, including 0 and 255. It
// fills the node space completely, and it sweeps every node into one ring so
// that each ring is seen empty while the other is busy.
// ---------------------------------------------------------------------------
module tb_top;
    import tcrr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RING_ACT    = 0;
    localparam int RING_SB     = 1;
    localparam int BURST_MAX   = 17;

    // DUT connections. Every input has a known value from time zero.
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    item_t              item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_t            result;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [RATIO_W-1:0] cfg_data     = '0;

    // Behavioral copy of the scheduler state. Index 0 of the ring arrays is
    // the active ring and index 1 is the standby ring.
    node_t              ring_slot [2][MAX_NODES];
    node_t              ring_head [2];
    len_t               ring_len  [2];
    memb_t              node_memb [MAX_NODES];
    logic [7:0]         served_cnt;
    logic [RATIO_W-1:0] ratio_q;

    // Items waiting to be driven, and results still owed by the block.
    item_t   item_backlog [$];
    result_t outcome_q    [$];
    result_t predicted;
    result_t want;

    // Burst idling on each side. A percentage of zero disables it.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap      = 0;
    int recv_gap      = 0;

    int errors      = 0;
    int cycle_cnt   = 0;
    int n_items     = 0;
    int n_requests  = 0;
    int n_sb_grants = 0;
    int n_cfg       = 0;
    int peak_active = 0;
    int peak_sb     = 0;

    two_class_interleaved_round_robin uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Ring model
    // -----------------------------------------------------------------------
    // Slot positions wrap by truncation to the node width. That is exact
    // because the ring depth equals the node space of 256.

    function automatic void ring_push(int r, node_t n);
        if (ring_len[r] < len_t'(MAX_NODES))
        begin
            ring_slot[r][node_t'(ring_head[r] + ring_len[r])] = n;
            ring_len[r] = ring_len[r] + 1'b1;
        end
    endfunction

    // Removing a node closes the gap, so the service order of the remaining
    // nodes is kept.
    function automatic void ring_take_out(int r, node_t n);
        int pos = -1;
        for (int i = 0; i < ring_len[r]; i++)
        begin
            if (pos < 0 && ring_slot[r][node_t'(ring_head[r] + i)] == n)
                pos = i;
        end
        if (pos < 0)
            return;
        for (int j = pos; j + 1 < ring_len[r]; j++)
            ring_slot[r][node_t'(ring_head[r] + j)] =
                ring_slot[r][node_t'(ring_head[r] + j + 1)];
        ring_len[r] = ring_len[r] - 1'b1;
    endfunction

    // The head node is served and goes to the tail.
    function automatic node_t ring_turn(int r);
        node_t n;
        n = ring_slot[r][ring_head[r]];
        ring_slot[r][node_t'(ring_head[r] + ring_len[r])] = n;
        ring_head[r] = ring_head[r] + 1'b1;
        return n;
    endfunction

    function automatic void relocate_node(node_t n, memb_t dst);
        if (node_memb[n] == dst)
            return;
        if (node_memb[n] == MEMB_ACTIVE)
            ring_take_out(RING_ACT, n);
        else if (node_memb[n] == MEMB_STANDBY)
            ring_take_out(RING_SB, n);
        ring_push((dst == MEMB_ACTIVE) ? RING_ACT : RING_SB, n);
        node_memb[n] = dst;
    endfunction

    // Applies one item to the model and returns the result it must produce.
    function automatic result_t schedule_outcome(item_t it);
        result_t r;
        r = '0;
        if (it.kind == KIND_REQUEST)
        begin
            if (ring_len[RING_ACT] == 0 && ring_len[RING_SB] == 0)
            begin
                // Nothing to serve: the result stays invalid.
            end
            else if (ring_len[RING_ACT] == 0)
            begin
                r.next_node    = ring_turn(RING_SB);
                r.next_valid   = 1'b1;
                r.from_standby = 1'b1;
            end
            else if (ring_len[RING_SB] == 0 || served_cnt < ratio_q)
            begin
                r.next_node  = ring_turn(RING_ACT);
                r.next_valid = 1'b1;
                if (served_cnt != 8'hFF)
                    served_cnt = served_cnt + 1'b1;
            end
            else
            begin
                r.next_node    = ring_turn(RING_SB);
                r.next_valid   = 1'b1;
                r.from_standby = 1'b1;
                served_cnt     = '0;
            end
        end
        else if (it.kind == KIND_REGISTER)
        begin
            if (node_memb[it.node_id] == MEMB_NONE)
                relocate_node(it.node_id, MEMB_STANDBY);
        end
        else if (it.kind == KIND_TO_ACTIVE)
            relocate_node(it.node_id, MEMB_ACTIVE);
        else
            relocate_node(it.node_id, MEMB_STANDBY);
        r.active_count  = ring_len[RING_ACT];
        r.standby_count = ring_len[RING_SB];
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Item driver
    // -----------------------------------------------------------------------
    // The expectation is formed at the edge where the item transaction is
    // accepted. The result comes from an output register and can only show
    // up at a later edge. Valid is held with a stable payload until the
    // transaction completes. After an item is launched, an idle burst may
    // follow.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                predicted = schedule_outcome(item);
                outcome_q.insert(outcome_q.size(), predicted);
                n_items++;
                if (item.kind == KIND_REQUEST)
                    n_requests++;
                if (predicted.from_standby)
                    n_sb_grants++;
                if (predicted.active_count > peak_active)
                    peak_active = predicted.active_count;
                if (predicted.standby_count > peak_sb)
                    peak_sb = predicted.standby_count;
            end
            if (item_valid && !item_ready)
            begin
                // The transaction is still pending; keep everything stable.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (item_backlog.size() > 0)
            begin
                item       <= item_backlog[0];
                item_backlog.delete(0);
                item_valid <= 1'b1;
                if ($urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(1, BURST_MAX);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor
    // -----------------------------------------------------------------------
    task automatic check_field(string fname, int exp_v, int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, fname, exp_v, got_v);
            errors++;
        end
    endtask

    // Results are sampled at the edge where the transaction completes. The
    // ready line runs high with random stall bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, result);
                    errors++;
                end
                else
                begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    check_field("next_node", want.next_node, result.next_node);
                    check_field("next_valid", want.next_valid, result.next_valid);
                    check_field("from_standby", want.from_standby, result.from_standby);
                    check_field("active_count", want.active_count, result.active_count);
                    check_field("standby_count", want.standby_count,
                                result.standby_count);
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 99) < recv_idle_pct)
                    recv_gap = $urandom_range(1, BURST_MAX);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus sequencing
    // -----------------------------------------------------------------------
    task automatic queue_item(logic [KIND_W-1:0] k, int id);
        item_t it;
        it.kind    = k;
        it.node_id = ID_W'(id);
        item_backlog.insert(item_backlog.size(), it);
    endtask

    // Most node numbers come from a small pool, so that registers and moves
    // keep hitting nodes that are already placed. The rest cover the full
    // node space. The node field of requests is random as well, even though
    // the block ignores it.
    task automatic queue_random(int count, int req_pct, int pool, int base);
        logic [KIND_W-1:0] k;
        int                id;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < req_pct)
                k = KIND_REQUEST;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       k = KIND_REGISTER;
                    1:       k = KIND_TO_ACTIVE;
                    default: k = KIND_TO_STANDBY;
                endcase
            end
            if ($urandom_range(0, 99) < 75)
                id = (base + $urandom_range(0, pool - 1)) % MAX_NODES;
            else
                id = $urandom_range(0, MAX_NODES - 1);
            queue_item(k, id);
        end
    endtask

    // Moves every node currently held in one ring to the other one. This is
    // only called while the block is idle, so the model state is exact.
    task automatic queue_sweep(memb_t from, logic [KIND_W-1:0] k);
        int start;
        start = $urandom_range(0, MAX_NODES - 1);
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (node_memb[(start + i) % MAX_NODES] == from)
                queue_item(k, (start + i) % MAX_NODES);
        end
    endtask

    // Registers every node once, in shuffled order.
    task automatic queue_fill();
        int order [MAX_NODES];
        int j;
        int t;
        foreach (order[i])
            order[i] = i;
        for (int i = MAX_NODES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i])
            queue_item(KIND_REGISTER, order[i]);
    endtask

    task automatic queue_requests(int count);
        for (int i = 0; i < count; i++)
            queue_item(KIND_REQUEST, $urandom_range(0, MAX_NODES - 1));
    endtask

    // Sampling on the falling edge keeps this check clear of the driver's and
    // monitor's updates at the rising edge.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (item_backlog.size() != 0 || item_valid || outcome_q.size() != 0);
    endtask

    // Each transaction on the configuration channel produces no result, so
    // an empty expectation queue means the block is idle.
    task automatic write_ratio(int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= RATIO_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        ratio_q = RATIO_W'(value);
        n_cfg++;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        foreach (node_memb[i])
            node_memb[i] = MEMB_NONE;
        foreach (ring_slot[r, i])
            ring_slot[r][i] = '0;
        ring_head  = '{default: '0};
        ring_len   = '{default: '0};
        served_cnt = '0;
        ratio_q    = RATIO_RESET;

        // Directed opening at the reset ratio of 1. It checks a request with
        // both rings empty, a repeated register, moves into the ring that
        // already holds the node, the alternation between the rings, each
        // ring rotating alone, and moves of nodes that were never registered.
        queue_item(KIND_REQUEST, 255);
        queue_item(KIND_REGISTER, 0);
        queue_item(KIND_REGISTER, 255);
        queue_item(KIND_REGISTER, 0);
        queue_item(KIND_REQUEST, 0);
        queue_item(KIND_TO_ACTIVE, 255);
        queue_item(KIND_TO_ACTIVE, 255);
        queue_item(KIND_REQUEST, 170);
        queue_item(KIND_REQUEST, 85);
        queue_item(KIND_REQUEST, 0);
        queue_item(KIND_REGISTER, 255);
        queue_item(KIND_TO_ACTIVE, 0);
        queue_item(KIND_REQUEST, 1);
        queue_item(KIND_REQUEST, 2);
        queue_item(KIND_REQUEST, 4);
        queue_item(KIND_TO_STANDBY, 0);
        queue_item(KIND_TO_STANDBY, 0);
        queue_item(KIND_TO_STANDBY, 255);
        queue_item(KIND_REQUEST, 8);
        queue_item(KIND_TO_ACTIVE, 170);
        queue_item(KIND_TO_STANDBY, 85);
        queue_item(KIND_REQUEST, 16);
        queue_item(KIND_REQUEST, 32);
        queue_item(KIND_REQUEST, 64);

        send_idle_pct = 15;
        recv_idle_pct = 10;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // With a ratio of 0, standby is served whenever both rings hold nodes.
        write_ratio(0);
        send_idle_pct = 20;
        recv_idle_pct = 8;
        queue_random(200, 40, 16, $urandom_range(0, MAX_NODES - 1));
        wait_drained();

        // Largest ratio. All nodes are gathered in the active ring first, so
        // the long run of requests drives the served count into saturation.
        // The random traffic after that brings standby nodes back in.
        write_ratio(255);
        send_idle_pct = 5;
        recv_idle_pct = 25;
        queue_sweep(MEMB_STANDBY, KIND_TO_ACTIVE);
        queue_requests(270);
        queue_random(100, 85, 8, $urandom_range(0, MAX_NODES - 1));
        wait_drained();

        write_ratio(3);
        send_idle_pct = 30;
        recv_idle_pct = 3;
        queue_random(200, 45, 24, $urandom_range(0, MAX_NODES - 1));
        wait_drained();

        // Every node registered: the two rings together hold the whole node space.
        write_ratio(2);
        send_idle_pct = 10;
        recv_idle_pct = 10;
        queue_fill();
        queue_random(80, 50, MAX_NODES, 0);
        wait_drained();

        // Everything goes to standby, so the active ring is empty while
        // standby rotates. The random traffic after that refills active.
        write_ratio($urandom_range(4, 254));
        send_idle_pct = 0;
        recv_idle_pct = 15;
        queue_sweep(MEMB_ACTIVE, KIND_TO_STANDBY);
        queue_requests(40);
        queue_random(100, 40, 32, $urandom_range(0, MAX_NODES - 1));
        wait_drained();

        // Final stretch at full rate on both sides.
        write_ratio(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(200, 40, MAX_NODES, 0);
        wait_drained();
        repeat (16) @(negedge clk);

        if (outcome_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, outcome_q.size());
            errors++;
        end
        $display("Checked %0d items (%0d requests, %0d standby grants) over %0d ratio writes.",
                 n_items, n_requests, n_sb_grants, n_cfg);
        $display("Peak ring sizes: active %0d, standby %0d; %0d errors.",
                 peak_active, peak_sb, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule : tb_top
`default_nettype wire

@@ two_class_interleaved_round_robin.f @@
src/tcrr_pkg.sv
src/tcrr_link_store.sv
src/two_class_interleaved_round_robin.sv
sim/tb_top.sv
